FILE: src/alle_pkg.sv
// shared types and constants for the array linked list engine
// no dependencies

package alle_pkg;

   localparam int SLOTS_DEFAULT = 256;

   localparam logic [2:0] OP_PUSH_FRONT = 3'd0;
   localparam logic [2:0] OP_PUSH_BACK  = 3'd1;
   localparam logic [2:0] OP_INS_BEFORE = 3'd2;
   localparam logic [2:0] OP_INS_AFTER  = 3'd3;
   localparam logic [2:0] OP_DELETE     = 3'd4;
   localparam logic [2:0] OP_READ       = 3'd5;
   localparam logic [2:0] OP_FIND       = 3'd6;

   localparam logic [1:0] ST_OK       = 2'd0;
   localparam logic [1:0] ST_FULL     = 2'd1;
   localparam logic [1:0] ST_EMPTY    = 2'd2;
   localparam logic [1:0] ST_NOTFOUND = 2'd3;

   typedef enum logic [1:0] {
      MODE_FRONT,
      MODE_BACK,
      MODE_AFTER
   } mode_type;

   typedef enum logic [3:0] {
      S_CLEAR,
      S_IDLE,
      S_ALLOC,
      S_ALLOC2,
      S_WALK,
      S_LINK,
      S_INS_W2,
      S_FETCH,
      S_DEL_W2,
      S_FIND,
      S_RESULT
   } state_type;

   typedef struct packed {
      logic [2:0]  opcode;
      logic [7:0]  position;
      logic [63:0] value;
   } req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [7:0]  slot;
      logic [63:0] elem_value;
      logic [7:0]  count;
   } rsp_type;

endpackage

FILE: src/alle_store.sv
// slot memories: element words, next and previous links
// one shared read address with registered read data, one write port per memory; uses alle_pkg

module alle_store #(
   parameter int SLOTS = alle_pkg::SLOTS_DEFAULT,
   localparam int IW = $clog2(SLOTS)
) (
   input  logic          clock,
   input  logic [IW-1:0] rd_addr,
   output logic [63:0]   rd_data,
   output logic [IW-1:0] rd_next,
   output logic [IW-1:0] rd_prev,
   input  logic          we_data,
   input  logic [IW-1:0] wa_data,
   input  logic [63:0]   wd_data,
   input  logic          we_next,
   input  logic [IW-1:0] wa_next,
   input  logic [IW-1:0] wd_next,
   input  logic          we_prev,
   input  logic [IW-1:0] wa_prev,
   input  logic [IW-1:0] wd_prev
);

   logic [63:0]   data_mem [SLOTS];
   logic [IW-1:0] next_mem [SLOTS];
   logic [IW-1:0] prev_mem [SLOTS];

   always_ff @(posedge clock) begin
      if (we_data) begin
         data_mem[wa_data] <= wd_data;
      end
      if (we_next) begin
         next_mem[wa_next] <= wd_next;
      end
      if (we_prev) begin
         prev_mem[wa_prev] <= wd_prev;
      end
      rd_data <= data_mem[rd_addr];
      rd_next <= next_mem[rd_addr];
      rd_prev <= prev_mem[rd_addr];
   end

endmodule

FILE: src/alle_seq.sv
// operation sequencer: list registers, link walk, read-modify-write of the slot memories
// instantiates alle_store; uses alle_pkg

module alle_seq #(
   parameter int SLOTS = alle_pkg::SLOTS_DEFAULT,
   localparam int IW = $clog2(SLOTS),
   localparam int CW = IW + 8
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  alle_pkg::req_type req_data,
   output logic              res_valid,
   output alle_pkg::rsp_type res_data,
   input  logic              out_ready
);

   alle_pkg::state_type state_ff, state_in;
   alle_pkg::mode_type  mode_ff, mode_in;
   logic [2:0]    op_ff, op_in;
   logic [63:0]   val_ff, val_in;
   logic [63:0]   word_ff, word_in;
   logic [1:0]    status_ff, status_in;
   logic [IW-1:0] slot_ff, slot_in;
   logic [IW-1:0] cur_ff, cur_in;
   logic [IW-1:0] rem_ff, rem_in;
   logic          pend_ff, pend_in;
   logic [IW-1:0] nfree_ff, nfree_in;
   logic [IW-1:0] n_ff, n_in;
   logic [IW-1:0] p_ff, p_in;
   logic [IW-1:0] chk_ff, chk_in;
   logic [IW-1:0] clr_ff, clr_in;
   logic [IW-1:0] first_ff, first_in;
   logic [IW-1:0] last_ff, last_in;
   logic [IW-1:0] free_ff, free_in;
   logic [IW-1:0] cnt_ff, cnt_in;

   logic [IW-1:0] rd_addr, rd_next, rd_prev;
   logic [63:0]   rd_data;
   logic          we_data, we_next, we_prev;
   logic [IW-1:0] wa_data, wa_next, wd_next, wa_prev, wd_prev;
   logic [63:0]   wd_data;

   logic [IW-1:0] cur;
   logic [CW-1:0] pos_w, cnt_w, clamp_w;

   alle_store #(.SLOTS(SLOTS)) u_store (
      .clock   (clock),
      .rd_addr (rd_addr),
      .rd_data (rd_data),
      .rd_next (rd_next),
      .rd_prev (rd_prev),
      .we_data (we_data),
      .wa_data (wa_data),
      .wd_data (wd_data),
      .we_next (we_next),
      .wa_next (wa_next),
      .wd_next (wd_next),
      .we_prev (we_prev),
      .wa_prev (wa_prev),
      .wd_prev (wd_prev)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= alle_pkg::S_CLEAR;
         clr_ff   <= '0;
         first_ff <= IW'(1);
         last_ff  <= IW'(1);
         free_ff  <= IW'(1);
         cnt_ff   <= '0;
         pend_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         clr_ff   <= clr_in;
         first_ff <= first_in;
         last_ff  <= last_in;
         free_ff  <= free_in;
         cnt_ff   <= cnt_in;
         pend_ff  <= pend_in;
      end
      mode_ff   <= mode_in;
      op_ff     <= op_in;
      val_ff    <= val_in;
      word_ff   <= word_in;
      status_ff <= status_in;
      slot_ff   <= slot_in;
      cur_ff    <= cur_in;
      rem_ff    <= rem_in;
      nfree_ff  <= nfree_in;
      n_ff      <= n_in;
      p_ff      <= p_in;
      chk_ff    <= chk_in;
   end

   always_comb begin
      state_in  = state_ff;
      mode_in   = mode_ff;
      op_in     = op_ff;
      val_in    = val_ff;
      word_in   = word_ff;
      status_in = status_ff;
      slot_in   = slot_ff;
      cur_in    = cur_ff;
      rem_in    = rem_ff;
      pend_in   = pend_ff;
      nfree_in  = nfree_ff;
      n_in      = n_ff;
      p_in      = p_ff;
      chk_in    = chk_ff;
      clr_in    = clr_ff;
      first_in  = first_ff;
      last_in   = last_ff;
      free_in   = free_ff;
      cnt_in    = cnt_ff;
      rd_addr   = cur_ff;
      we_data   = 1'b0;
      wa_data   = free_ff;
      wd_data   = val_ff;
      we_next   = 1'b0;
      wa_next   = free_ff;
      wd_next   = free_ff;
      we_prev   = 1'b0;
      wa_prev   = free_ff;
      wd_prev   = free_ff;
      res_valid = 1'b0;
      cur       = pend_ff ? rd_next : cur_ff;
      pos_w     = CW'(req_data.position);
      cnt_w     = CW'(cnt_ff);
      clamp_w   = (pos_w == '0) ? CW'(1) : pos_w;
      if (clamp_w > cnt_w) begin
         clamp_w = cnt_w;
      end

      case (state_ff)
         alle_pkg::S_CLEAR: begin
            we_next = 1'b1;
            wa_next = clr_ff;
            wd_next = (clr_ff == IW'(SLOTS - 1)) ? '0 : IW'(clr_ff + 1'b1);
            clr_in  = IW'(clr_ff + 1'b1);
            if (clr_ff == IW'(SLOTS - 1)) begin
               state_in = alle_pkg::S_IDLE;
            end
         end
         alle_pkg::S_IDLE: begin
            if (req_valid) begin
               op_in     = req_data.opcode;
               val_in    = req_data.value;
               word_in   = '0;
               slot_in   = '0;
               status_in = alle_pkg::ST_OK;
               pend_in   = 1'b0;
               cur_in    = first_ff;
               rem_in    = '0;
               state_in  = alle_pkg::S_RESULT;
               case (req_data.opcode)
                  alle_pkg::OP_PUSH_FRONT, alle_pkg::OP_PUSH_BACK,
                  alle_pkg::OP_INS_BEFORE, alle_pkg::OP_INS_AFTER: begin
                     if (free_ff == '0) begin
                        status_in = alle_pkg::ST_FULL;
                     end else begin
                        state_in = alle_pkg::S_ALLOC;
                        cur_in   = last_ff;
                        mode_in  = alle_pkg::MODE_BACK;
                        if (req_data.opcode == alle_pkg::OP_PUSH_FRONT || cnt_ff == '0) begin
                           mode_in = alle_pkg::MODE_FRONT;
                        end else if (req_data.opcode == alle_pkg::OP_INS_BEFORE) begin
                           if (pos_w <= CW'(1)) begin
                              mode_in = alle_pkg::MODE_FRONT;
                           end else if (pos_w <= cnt_w) begin
                              mode_in = alle_pkg::MODE_AFTER;
                              cur_in  = first_ff;
                              rem_in  = IW'(pos_w - CW'(2));
                           end
                        end else if (req_data.opcode == alle_pkg::OP_INS_AFTER) begin
                           if (pos_w == '0) begin
                              mode_in = alle_pkg::MODE_FRONT;
                           end else if (pos_w < cnt_w) begin
                              mode_in = alle_pkg::MODE_AFTER;
                              cur_in  = first_ff;
                              rem_in  = IW'(pos_w - CW'(1));
                           end
                        end
                     end
                  end
                  alle_pkg::OP_DELETE, alle_pkg::OP_READ: begin
                     if (cnt_ff == '0) begin
                        status_in = alle_pkg::ST_EMPTY;
                     end else begin
                        rem_in   = IW'(clamp_w - CW'(1));
                        state_in = alle_pkg::S_WALK;
                     end
                  end
                  alle_pkg::OP_FIND: begin
                     if (cnt_ff == '0) begin
                        status_in = alle_pkg::ST_EMPTY;
                     end else begin
                        rem_in   = cnt_ff;
                        state_in = alle_pkg::S_FIND;
                     end
                  end
                  default: begin
                     state_in = alle_pkg::S_RESULT;
                  end
               endcase
            end
         end
         alle_pkg::S_ALLOC: begin
            rd_addr  = free_ff;
            state_in = alle_pkg::S_ALLOC2;
         end
         alle_pkg::S_ALLOC2: begin
            nfree_in = rd_next;
            if (cnt_ff == '0) begin
               we_data  = 1'b1;
               we_next  = 1'b1;
               we_prev  = 1'b1;
               first_in = free_ff;
               last_in  = free_ff;
               free_in  = rd_next;
               cnt_in   = IW'(cnt_ff + 1'b1);
               slot_in  = free_ff;
               state_in = alle_pkg::S_RESULT;
            end else begin
               state_in = alle_pkg::S_WALK;
            end
         end
         alle_pkg::S_WALK: begin
            cur_in  = cur;
            rd_addr = cur;
            if (rem_ff == '0) begin
               pend_in  = 1'b0;
               state_in = (op_ff == alle_pkg::OP_DELETE || op_ff == alle_pkg::OP_READ)
                          ? alle_pkg::S_FETCH : alle_pkg::S_LINK;
            end else begin
               rem_in  = IW'(rem_ff - 1'b1);
               pend_in = 1'b1;
            end
         end
         alle_pkg::S_LINK: begin
            we_data  = 1'b1;
            we_next  = 1'b1;
            wd_next  = rd_next;
            we_prev  = 1'b1;
            wd_prev  = cur_ff;
            n_in     = rd_next;
            state_in = alle_pkg::S_INS_W2;
         end
         alle_pkg::S_INS_W2: begin
            we_next = 1'b1;
            wa_next = cur_ff;
            we_prev = 1'b1;
            wa_prev = n_ff;
            free_in = nfree_ff;
            cnt_in  = IW'(cnt_ff + 1'b1);
            slot_in = free_ff;
            case (mode_ff)
               alle_pkg::MODE_FRONT: first_in = free_ff;
               alle_pkg::MODE_BACK:  last_in = free_ff;
               default: begin
                  if (cur_ff == last_ff) begin
                     last_in = free_ff;
                  end
               end
            endcase
            state_in = alle_pkg::S_RESULT;
         end
         alle_pkg::S_FETCH: begin
            word_in = rd_data;
            slot_in = cur_ff;
            if (op_ff == alle_pkg::OP_READ) begin
               state_in = alle_pkg::S_RESULT;
            end else begin
               we_next  = 1'b1;
               wa_next  = rd_prev;
               wd_next  = rd_next;
               we_prev  = 1'b1;
               wa_prev  = rd_next;
               wd_prev  = rd_prev;
               p_in     = rd_prev;
               n_in     = rd_next;
               state_in = alle_pkg::S_DEL_W2;
            end
         end
         alle_pkg::S_DEL_W2: begin
            we_next = 1'b1;
            wa_next = cur_ff;
            wd_next = free_ff;
            if (cur_ff == first_ff) begin
               first_in = n_ff;
            end
            if (cur_ff == last_ff) begin
               last_in = p_ff;
            end
            free_in  = cur_ff;
            cnt_in   = IW'(cnt_ff - 1'b1);
            state_in = alle_pkg::S_RESULT;
         end
         alle_pkg::S_FIND: begin
            if (pend_ff && rd_data == val_ff) begin
               slot_in  = chk_ff;
               state_in = alle_pkg::S_RESULT;
            end else if (rem_ff == '0) begin
               status_in = alle_pkg::ST_NOTFOUND;
               state_in  = alle_pkg::S_RESULT;
            end else begin
               rd_addr = cur;
               chk_in  = cur;
               cur_in  = cur;
               rem_in  = IW'(rem_ff - 1'b1);
               pend_in = 1'b1;
            end
         end
         alle_pkg::S_RESULT: begin
            res_valid = 1'b1;
            pend_in   = 1'b0;
            if (out_ready) begin
               state_in = alle_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = alle_pkg::S_IDLE;
         end
      endcase
   end

   assign req_stall           = (state_ff != alle_pkg::S_IDLE);
   assign res_data.status     = status_ff;
   assign res_data.slot       = 8'(slot_ff);
   assign res_data.elem_value = word_ff;
   assign res_data.count      = 8'(cnt_ff);

endmodule

FILE: src/array_linked_list_engine_core.sv
// top level of the array linked list engine: sequencer and result output register
// instantiates alle_seq; uses alle_pkg

// One operation is worked at a time. After reset a pass over every slot builds the free
// chain, during which req_stall stays high. An insert reads the head of the free chain,
// walks to the insertion point when insert before or insert after needs it, then writes
// the new slot and its links and patches the neighbours' links; read and delete walk to
// the position (positions clamped to the element count) and fetch the slot, and delete
// unlinks it and then puts it back on the free chain; find compares each visited element
// with the value. The walk follows one link per cycle through the registered read port
// of the link memory. An empty-list or full-store rejection and an undefined opcode go
// straight to the result. The result sits in an output register, so the next beat is
// accepted while it waits for the receiver.

module array_linked_list_engine_core #(
   parameter int SLOTS = alle_pkg::SLOTS_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  alle_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output alle_pkg::rsp_type rsp_data
);

   logic              res_valid;
   alle_pkg::rsp_type res_data;
   logic              out_ready;
   logic              rsp_valid_ff, rsp_valid_in;
   alle_pkg::rsp_type rsp_data_ff, rsp_data_in;

   alle_seq #(.SLOTS(SLOTS)) u_seq (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .res_valid (res_valid),
      .res_data  (res_data),
      .out_ready (out_ready)
   );

   assign out_ready = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (out_ready) begin
         rsp_valid_in = res_valid;
         if (res_valid) begin
            rsp_data_in = res_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule
